// ===== sv/grid_ray_wall_intersection_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid ray caster
// Shared concurrent assertion forms, clocked, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_WALL_INTERSECTION_DEFINES_SVH
`define GRID_RAY_WALL_INTERSECTION_DEFINES_SVH

// same-cycle implication
`define GRWI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GRWI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/grwi_pkg.sv =====
// ----------------------------------------------------------------------------
// grwi_pkg
// Item types, register indexes and sequencer states of the grid ray caster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grwi_pkg;

    localparam int POS_W      = 20;
    localparam int SLOPE_W    = 24;
    localparam int CELL_W     = 6;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int FRAC_SHIFT = 16;
    localparam int NUDGE      = 256;
    localparam int POS_MAX    = 1048575;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic                      action;
        logic [CELL_W-1:0]         cell_col;
        logic [CELL_W-1:0]         cell_row;
        logic                      cell_is_wall;
        logic [POS_W-1:0]          player_x;
        logic [POS_W-1:0]          player_y;
        logic signed [SLOPE_W-1:0] ray_tan;
        logic signed [SLOPE_W-1:0] ray_cot;
        logic                      facing_down;
        logic                      facing_right;
    } t_in_item;

    typedef struct packed {
        logic             horiz_hit;
        logic [POS_W-1:0] horiz_x;
        logic [POS_W-1:0] horiz_y;
        logic             vert_hit;
        logic [POS_W-1:0] vert_x;
        logic [POS_W-1:0] vert_y;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,   // map clearing pass after reset
        ST_IDLE,    // waiting for an item
        ST_DIVM,    // grid line of player: multiply by reciprocal
        ST_DIVC,    // grid line of player: correct quotient
        ST_OFFM,    // first crossing offset: multiply
        ST_OFFC,    // first crossing offset: add
        ST_STPM,    // step along grid: multiply
        ST_STPC,    // step along grid: magnitude and sign
        ST_CHK,     // sign and bounds test of current point
        ST_COLM,    // cell column: multiply
        ST_COLC,    // cell column: correct
        ST_ROWM,    // cell row: multiply
        ST_ROWC,    // cell row: correct
        ST_RD,      // map read
        ST_WAIT,    // map data back
        ST_DONE     // result waits for output register
    } t_state;

endpackage

// ===== sv/grid_ray_wall_intersection.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_intersection
// Wall bit map and two-pass grid ray caster on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_in_item) carries map writes
//   (action 0) and casts (action 1). Output channel (o_out_valid /
//   i_out_stall, o_out_item) carries one result per cast, none per write.
//   Configuration writes (i_cfg_valid / o_cfg_ready) set map width/height.
// Operation:
//   A map write is done in the idle state, which stays ready for the next
//   item. A cast runs a horizontal and then a vertical march. Each grid
//   line tested costs two passes through the shared multiplier (reciprocal
//   divide for column and row) plus one map RAM read; march setup costs
//   three multiplier passes. The block takes one item at a time and stalls
//   input while casting.
// Reset:
//   Map width/height registers return to 64 and the map RAM is swept to
//   zero, one cell a cycle, over all MAP_SIDE*MAP_SIDE cells; input stalls
//   meanwhile, configuration writes are taken.
// Output stall:
//   A finished result sits in the output register; a new item is taken
//   meanwhile, and a following cast holds its result until the slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_ray_wall_intersection_defines.svh"

module grid_ray_wall_intersection #(
    parameter int MAP_SIDE = 64,
    parameter int TILE     = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  grwi_pkg::t_in_item                     i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output grwi_pkg::t_out_item                    o_out_item,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [grwi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [grwi_pkg::DIM_W-1:0]             i_cfg_data
);

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int TQ        = TILE * 256;              // tile in Q12.8
    localparam int TQW       = $clog2(TQ + 1);
    localparam int DIV_SHIFT = (TQW + 7 > 20) ? TQW + 7 : 20;
    localparam int RECIP     = (2 ** DIV_SHIFT) / TQ;
    localparam int QW        = DIV_SHIFT - TQW + 1;     // quotient bits
    localparam int PW        = DIV_SHIFT + 3;           // signed position bits
    localparam int MA_W      = DIV_SHIFT + 1;           // multiplier operand a
    localparam int MW        = MA_W + grwi_pkg::SLOPE_W;
    localparam int DEPTH     = MAP_SIDE * MAP_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int CAP       = MAP_SIDE + 4;
    localparam int NW        = $clog2(CAP + 1);

    typedef logic signed [PW-1:0]                   t_pos;
    typedef logic signed [MA_W-1:0]                 t_ma;
    typedef logic signed [MW-1:0]                   t_prod;
    typedef logic signed [grwi_pkg::SLOPE_W-1:0]    t_slope;
    typedef logic [DIV_SHIFT:0]                     t_rem;
    typedef logic [QW-1:0]                          t_q;
    typedef logic [AW-1:0]                          t_addr;
    typedef logic [NW-1:0]                          t_n;
    typedef logic [grwi_pkg::DIM_W-1:0]             t_dim;
    typedef logic [grwi_pkg::POS_W-1:0]             t_coord;

    localparam t_pos   TQ_P    = t_pos'(TQ);
    localparam t_pos   NUDGE_P = t_pos'(grwi_pkg::NUDGE);
    localparam t_pos   PMAX_P  = t_pos'(grwi_pkg::POS_MAX);
    localparam t_slope RECIP_B = t_slope'(RECIP);

    // register value above the store size is used as the store size
    function automatic t_dim eff_dim(input t_dim r);
        if (32'(r) > 32'(MAP_SIDE)) begin
            return t_dim'(MAP_SIDE);
        end
        return r;
    endfunction

    function automatic t_coord sat_pos(input t_pos v);
        if (v[PW-1]) begin
            return '0;
        end else if (v > PMAX_P) begin
            return t_coord'(PMAX_P);
        end
        return t_coord'(v);
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    grwi_pkg::t_state    r_state, n_state;
    t_dim                r_map_w, r_map_h;
    grwi_pkg::t_in_item  r_item, n_item;
    logic                r_vert, n_vert;
    t_pos                r_x, n_x, r_y, n_y;
    t_pos                r_dx, n_dx, r_dy, n_dy;
    t_pos                r_diff, n_diff;
    t_pos                r_tx, n_tx, r_ty, n_ty;
    t_q                  r_col, n_col, r_row, n_row;
    t_n                  r_n, n_n;
    t_prod               r_prod, n_prod;
    t_addr               r_clr, n_clr;
    logic                r_h_hit, n_h_hit;
    t_coord              r_h_x, n_h_x, r_h_y, n_h_y;
    logic                r_v_hit, n_v_hit;
    t_coord              r_v_x, n_v_x, r_v_y, n_v_y;
    grwi_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    t_dim               eff_w, eff_h;
    t_pos               lim_w, lim_h;
    logic               in_acc;
    logic [grwi_pkg::POS_W-1:0] p_pri;
    t_slope             slope;
    t_ma                mul_a;
    t_slope             mul_b;
    logic [DIV_SHIFT-1:0] div_num;
    t_q                 q_est, div_q;
    t_rem               div_back, div_rem;
    t_pos               base, off, mag, prod_sh;
    t_prod              prod_abs;
    t_pos               nx, ny, tx, ty;
    logic               end_march, end_hit;
    logic               ram_we, ram_wdata, ram_rdata;
    t_addr              ram_waddr, ram_raddr;

    assign eff_w  = eff_dim(r_map_w);
    assign eff_h  = eff_dim(r_map_h);
    assign lim_w  = t_pos'(eff_w) * TQ_P;
    assign lim_h  = t_pos'(eff_h) * TQ_P;
    assign in_acc = i_in_valid && !o_in_stall;

    // coordinate that the march direction crosses, and its slope
    assign p_pri = r_vert ? r_item.player_x : r_item.player_y;
    assign slope = r_vert ? r_item.ray_tan : r_item.ray_cot;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            grwi_pkg::ST_DIVM: begin
                mul_a = t_ma'(p_pri);
                mul_b = RECIP_B;
            end
            grwi_pkg::ST_OFFM: begin
                mul_a = t_ma'(r_diff);
                mul_b = slope;
            end
            grwi_pkg::ST_STPM: begin
                mul_a = t_ma'(TQ_P);
                mul_b = slope;
            end
            grwi_pkg::ST_COLM: begin
                mul_a = t_ma'(r_tx);
                mul_b = RECIP_B;
            end
            grwi_pkg::ST_ROWM: begin
                mul_a = t_ma'(r_ty);
                mul_b = RECIP_B;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = t_prod'(mul_a) * t_prod'(mul_b);

    // divide by tile: reciprocal estimate is low by at most one
    always_comb begin
        case (r_state)
            grwi_pkg::ST_COLM, grwi_pkg::ST_COLC: div_num = r_tx[DIV_SHIFT-1:0];
            grwi_pkg::ST_ROWM, grwi_pkg::ST_ROWC: div_num = r_ty[DIV_SHIFT-1:0];
            default:                              div_num = DIV_SHIFT'(p_pri);
        endcase
    end

    assign q_est    = r_prod[DIV_SHIFT +: QW];
    assign div_back = t_rem'(q_est) * t_rem'(TQ);
    assign div_rem  = t_rem'(div_num) - div_back;
    assign div_q    = (div_rem >= t_rem'(TQ)) ? q_est + t_q'(1) : q_est;

    // setup arithmetic
    assign base     = t_pos'(div_q) * TQ_P
                    + (((r_vert ? r_item.facing_right : r_item.facing_down)) ? TQ_P : '0);
    assign prod_sh  = t_pos'(r_prod >>> grwi_pkg::FRAC_SHIFT);
    assign off      = prod_sh;
    assign prod_abs = r_prod[MW-1] ? -r_prod : r_prod;
    assign mag      = t_pos'(prod_abs >> grwi_pkg::FRAC_SHIFT);

    // test point, nudged back one unit when facing up or left
    assign nx = (r_vert && !r_item.facing_right) ? -NUDGE_P : '0;
    assign ny = (!r_vert && !r_item.facing_down) ? -NUDGE_P : '0;
    assign tx = r_x + nx;
    assign ty = r_y + ny;

    // ------------------------------------------------------------------
    // sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_vert      = r_vert;
        n_x         = r_x;
        n_y         = r_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_diff      = r_diff;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_col       = r_col;
        n_row       = r_row;
        n_n         = r_n;
        n_clr       = r_clr;
        n_h_hit     = r_h_hit;
        n_h_x       = r_h_x;
        n_h_y       = r_h_y;
        n_v_hit     = r_v_hit;
        n_v_x       = r_v_x;
        n_v_y       = r_v_y;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        end_march   = 1'b0;
        end_hit     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = 1'b0;
        ram_raddr   = t_addr'(r_row) * t_addr'(MAP_SIDE) + t_addr'(r_col);

        case (r_state)
            grwi_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + t_addr'(1);
                if (r_clr == t_addr'(DEPTH - 1)) begin
                    n_state = grwi_pkg::ST_IDLE;
                end
            end
            grwi_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                ram_waddr  = t_addr'(i_in_item.cell_row) * t_addr'(MAP_SIDE)
                           + t_addr'(i_in_item.cell_col);
                ram_wdata  = i_in_item.cell_is_wall;
                if (i_in_valid) begin
                    if (!i_in_item.action) begin
                        // cells outside the store are dropped
                        ram_we = (32'(i_in_item.cell_col) < 32'(MAP_SIDE))
                              && (32'(i_in_item.cell_row) < 32'(MAP_SIDE));
                    end else begin
                        n_item  = i_in_item;
                        n_vert  = 1'b0;
                        n_state = grwi_pkg::ST_DIVM;
                    end
                end
            end
            grwi_pkg::ST_DIVM: begin
                n_state = grwi_pkg::ST_DIVC;
            end
            grwi_pkg::ST_DIVC: begin
                // first grid line and fixed step along the march axis
                n_diff = base - t_pos'(p_pri);
                n_n    = '0;
                if (r_vert) begin
                    n_x  = base;
                    n_dx = r_item.facing_right ? TQ_P : -TQ_P;
                end else begin
                    n_y  = base;
                    n_dy = r_item.facing_down ? TQ_P : -TQ_P;
                end
                n_state = grwi_pkg::ST_OFFM;
            end
            grwi_pkg::ST_OFFM: begin
                n_state = grwi_pkg::ST_OFFC;
            end
            grwi_pkg::ST_OFFC: begin
                if (r_vert) begin
                    n_y = t_pos'(r_item.player_y) + off;
                end else begin
                    n_x = t_pos'(r_item.player_x) + off;
                end
                n_state = grwi_pkg::ST_STPM;
            end
            grwi_pkg::ST_STPM: begin
                n_state = grwi_pkg::ST_STPC;
            end
            grwi_pkg::ST_STPC: begin
                if (r_vert) begin
                    n_dy = r_item.facing_down ? mag : -mag;
                end else begin
                    n_dx = r_item.facing_right ? mag : -mag;
                end
                n_state = grwi_pkg::ST_CHK;
            end
            grwi_pkg::ST_CHK: begin
                if (r_n == t_n'(CAP)) begin
                    end_march = 1'b1;
                end else if (r_x[PW-1] || r_y[PW-1]) begin
                    // march went negative: miss
                    end_march = 1'b1;
                end else if (tx[PW-1] || ty[PW-1] || (tx > lim_w) || (ty > lim_h)) begin
                    end_march = 1'b1;
                    end_hit   = 1'b1;
                end else begin
                    n_tx    = tx;
                    n_ty    = ty;
                    n_state = grwi_pkg::ST_COLM;
                end
            end
            grwi_pkg::ST_COLM: begin
                n_state = grwi_pkg::ST_COLC;
            end
            grwi_pkg::ST_COLC: begin
                n_col   = div_q;
                n_state = grwi_pkg::ST_ROWM;
            end
            grwi_pkg::ST_ROWM: begin
                n_state = grwi_pkg::ST_ROWC;
            end
            grwi_pkg::ST_ROWC: begin
                n_row   = div_q;
                n_state = grwi_pkg::ST_RD;
            end
            grwi_pkg::ST_RD: begin
                // cell beyond the map in use counts as wall
                if ((r_col >= t_q'(eff_w)) || (r_row >= t_q'(eff_h))) begin
                    end_march = 1'b1;
                    end_hit   = 1'b1;
                end else begin
                    n_state = grwi_pkg::ST_WAIT;
                end
            end
            grwi_pkg::ST_WAIT: begin
                if (ram_rdata) begin
                    end_march = 1'b1;
                    end_hit   = 1'b1;
                end else begin
                    n_x     = r_x + r_dx;
                    n_y     = r_y + r_dy;
                    n_n     = r_n + t_n'(1);
                    n_state = grwi_pkg::ST_CHK;
                end
            end
            grwi_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.horiz_hit = r_h_hit;
                    n_out.horiz_x   = r_h_x;
                    n_out.horiz_y   = r_h_y;
                    n_out.vert_hit  = r_v_hit;
                    n_out.vert_x    = r_v_x;
                    n_out.vert_y    = r_v_y;
                    n_out_valid     = 1'b1;
                    n_state         = grwi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = grwi_pkg::ST_IDLE;
            end
        endcase

        // close a march: horizontal goes on to vertical, vertical finishes
        if (end_march) begin
            if (!r_vert) begin
                n_h_hit = end_hit;
                n_h_x   = end_hit ? sat_pos(r_x) : '0;
                n_h_y   = end_hit ? sat_pos(r_y) : '0;
                n_vert  = 1'b1;
                n_state = grwi_pkg::ST_DIVM;
            end else begin
                n_v_hit = end_hit;
                n_v_x   = end_hit ? sat_pos(r_x) : '0;
                n_v_y   = end_hit ? sat_pos(r_y) : '0;
                n_state = grwi_pkg::ST_DONE;
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grwi_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_map_w     <= grwi_pkg::DIM_RESET;
            r_map_h     <= grwi_pkg::DIM_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    grwi_pkg::CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                    grwi_pkg::CFG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                    default: begin
                        r_map_w <= r_map_w;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_vert  <= n_vert;
        r_x     <= n_x;
        r_y     <= n_y;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_diff  <= n_diff;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_col   <= n_col;
        r_row   <= n_row;
        r_n     <= n_n;
        r_prod  <= n_prod;
        r_h_hit <= n_h_hit;
        r_h_x   <= n_h_x;
        r_h_y   <= n_h_y;
        r_v_hit <= n_v_hit;
        r_v_x   <= n_v_x;
        r_v_y   <= n_v_y;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------------
    // wall map store
    // ------------------------------------------------------------------
    grwi_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GRWI_ASSERT_IMP(a_div_range, i_clk, i_rst_n, (r_state == grwi_pkg::ST_DIVC) || (r_state == grwi_pkg::ST_COLC) || (r_state == grwi_pkg::ST_ROWC), div_rem < t_rem'(2 * TQ), "reciprocal quotient off by more than one")
    `GRWI_ASSERT_IMP(a_map_write, i_clk, i_rst_n, ram_we, (r_state == grwi_pkg::ST_IDLE) || (r_state == grwi_pkg::ST_CLEAR), "map written during a cast")
    `GRWI_ASSERT_NXT(a_cast_start, i_clk, i_rst_n, in_acc && i_in_item.action, (r_state == grwi_pkg::ST_DIVM) && !r_vert, "cast did not start on horizontal march")

endmodule

// ===== sv/grwi_ram.sv =====
// ----------------------------------------------------------------------------
// grwi_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grwi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
